/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge; hold off while reset is high.
`define SNFCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every clock edge, reset included.
`define SNFCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/snfcs_pkg.sv */
// Shared constants, result record type and helpers for the SPI NOR command sequencer.
// No dependencies; used by the top level and its checker.
package snfcs_pkg;

  localparam int PAGE_BYTES   = 256;  // power of two
  localparam int ADDRESS_BITS = 24;
  localparam int PAGE_LOG     = $clog2(PAGE_BYTES);
  localparam int PAGE_W       = PAGE_LOG + 1;
  localparam logic [23:0] ADDR_MASK = 24'((64'd1 << ADDRESS_BITS) - 64'd1);

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd2000;

  // Input item kinds
  localparam logic [2:0] K_READ      = 3'd0;
  localparam logic [2:0] K_PROGRAM   = 3'd1;
  localparam logic [2:0] K_ERASE     = 3'd2;
  localparam logic [2:0] K_PROBE     = 3'd3;
  localparam logic [2:0] K_DATA      = 3'd4;
  localparam logic [2:0] K_RESPONSE  = 3'd5;

  // Result kinds
  localparam logic [1:0] R_SPI       = 2'd0;
  localparam logic [1:0] R_HOST      = 2'd1;
  localparam logic [1:0] R_DONE      = 2'd2;

  // Completion status
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_ABSENT   = 2'd2;
  localparam logic [1:0] ST_REFUSED  = 2'd3;

  // Flash opcodes
  localparam logic [7:0] OPC_RDID    = 8'h9F;
  localparam logic [7:0] OPC_READ    = 8'h03;
  localparam logic [7:0] OPC_PP      = 8'h02;
  localparam logic [7:0] OPC_SE4K    = 8'h20;
  localparam logic [7:0] OPC_WREN    = 8'h06;
  localparam logic [7:0] OPC_RDSR    = 8'h05;
  localparam logic [7:0] DUMMY       = 8'hFF;

  // Operation codes
  localparam logic [2:0] OP_NONE     = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_PROG     = 3'd2;
  localparam logic [2:0] OP_ERASE    = 3'd3;
  localparam logic [2:0] OP_PROBE    = 3'd4;

  // Phase codes
  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_WREN      = 4'd1;
  localparam logic [3:0] PH_CMD       = 4'd2;
  localparam logic [3:0] PH_ADDR      = 4'd3;
  localparam logic [3:0] PH_READ      = 4'd4;
  localparam logic [3:0] PH_WAIT_DATA = 4'd5;
  localparam logic [3:0] PH_DATA      = 4'd6;
  localparam logic [3:0] PH_RDSR      = 4'd7;
  localparam logic [3:0] PH_POLL      = 4'd8;
  localparam logic [3:0] PH_RELEASE   = 4'd9;
  localparam logic [3:0] PH_PROBE     = 4'd10;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       release_cs;
    logic [1:0] status;
    logic       last;
  } res_t;

  function automatic res_t make_res(logic [1:0] kind, logic [7:0] value, logic rel,
                                    logic [1:0] status);
    res_t r;
    r.kind       = kind;
    r.value      = value;
    r.release_cs = rel;
    r.status     = status;
    r.last       = 1'b0;
    return r;
  endfunction

  // Bytes that fit in the current page, capped by what is left to program.
  function automatic logic [PAGE_W-1:0] page_room(logic [23:0] addr, logic [24:0] rem);
    logic [PAGE_W-1:0] pg;
    pg = PAGE_W'(PAGE_BYTES) - {1'b0, addr[PAGE_LOG-1:0]};
    if (25'(pg) > rem) pg = PAGE_W'(rem);
    return pg;
  endfunction

endpackage

/* hw/rtl/spi_nor_flash_command_sequencer.sv */
// SPI NOR flash command sequencer: top level.
// Depends on snfcs_pkg (constants, result record, page helper).
//
// Usage:
//   item channel (item_valid/item_ready): host requests (read, program, 4K erase,
//   id probe), program data bytes, and flash response beats carrying the MISO
//   byte of the last SPI byte sent. Exactly one SPI byte is outstanding at a time:
//   send every SPI result to the flash and return its MISO byte as a response beat.
//   result channel (result_valid/result_ready): SPI bytes to shift out (with a
//   chip-select release flag), id/read bytes for the host, and finished beats that
//   carry the status. last marks the final result caused by one item.
//   cfg_we/cfg_wdata: write poll_limit, only while the block is idle.
// Timing:
//   an accepted item lands in the input register and is decoded from there; its
//   results are registered into the result buffer, which drives the result port.
//   One item per cycle is sustained while result_ready stays high and each
//   item yields at most one result; an item yielding n results holds the
//   result port for n beats. The result buffer draining sets the pace.
// Reset (rst, synchronous): drop any buffered item and results, return to idle
//   with the device size unknown and poll_limit at 2000.
// Stall: while result_ready is low the buffered result holds; the input register
//   still takes one more item, then item_ready drops until the buffer can reload.
module spi_nor_flash_command_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [2:0]  kind,
  input  logic [23:0] address,
  input  logic [24:0] length,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  result_kind,
  output logic [7:0]  byte_value,
  output logic        release_select,
  output logic [1:0]  status,
  output logic        last
);

  // Configuration
  logic [15:0] poll_limit;

  // Input register
  logic        ir_valid;
  logic [2:0]  ir_kind;
  logic [23:0] ir_addr;
  logic [24:0] ir_len;
  logic [7:0]  ir_db;

  // Sequencer state
  logic [2:0]  operation, operation_next;
  logic [3:0]  phase, phase_next;
  logic [1:0]  abi, abi_next;                 // address / probe byte index
  logic [23:0] cur_addr, cur_addr_next;
  logic [24:0] remaining, remaining_next;
  logic [snfcs_pkg::PAGE_W-1:0] page_left, page_left_next;
  logic [15:0] poll_count, poll_count_next;
  logic [3:0]  size_exp, size_exp_next;
  logic        present, present_next;
  logic [15:0] id_hold, id_hold_next;

  // Result buffer: one item's results (at most two), drained one per beat
  snfcs_pkg::res_t res_q [3];
  snfcs_pkg::res_t res_new [3];
  logic [1:0]  res_cnt;
  logic [1:0]  res_head;
  logic [1:0]  new_cnt;

  logic        out_take;
  logic        advance;
  logic        load;

  // Decode helpers
  logic [31:0] dev_size;
  logic [25:0] end_addr;
  logic        over_end;
  logic        erase_over;
  logic [15:0] jedec;
  logic [snfcs_pkg::PAGE_W-1:0] pl_dec;
  logic [24:0] rem_dec;

  assign out_take   = result_valid && result_ready;
  // The buffer can reload when empty or when its final result leaves this cycle.
  assign advance    = (res_cnt == 2'd0) || (res_cnt == 2'd1 && result_ready);
  assign item_ready = !ir_valid || advance;
  assign load       = ir_valid && advance;

  assign dev_size   = 32'h0001_0000 << size_exp;
  assign end_addr   = 26'(ir_addr & snfcs_pkg::ADDR_MASK) + 26'(ir_len);
  assign over_end   = present && (32'(end_addr) > dev_size);
  assign erase_over = present && (32'(ir_addr & snfcs_pkg::ADDR_MASK) >= dev_size);
  assign jedec      = {id_hold[15:8], ir_db};
  assign pl_dec     = (page_left != '0) ? page_left - 1'b1 : page_left;
  assign rem_dec    = (remaining != '0) ? remaining - 25'd1 : remaining;

  always_comb begin
    operation_next  = operation;
    phase_next      = phase;
    abi_next        = abi;
    cur_addr_next   = cur_addr;
    remaining_next  = remaining;
    page_left_next  = page_left;
    poll_count_next = poll_count;
    size_exp_next   = size_exp;
    present_next    = present;
    id_hold_next    = id_hold;
    new_cnt         = 2'd0;
    for (int i = 0; i < 3; i++) begin
      res_new[i] = '0;
    end

    if (ir_valid) begin
      if (phase == snfcs_pkg::PH_IDLE &&
          (ir_kind == snfcs_pkg::K_READ || ir_kind == snfcs_pkg::K_PROGRAM)) begin
        if (ir_len == '0) begin
          res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                 snfcs_pkg::ST_OK);
          new_cnt = new_cnt + 2'd1;
        end else if (over_end) begin
          res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                 snfcs_pkg::ST_RANGE);
          new_cnt = new_cnt + 2'd1;
        end else begin
          cur_addr_next  = ir_addr & snfcs_pkg::ADDR_MASK;
          remaining_next = ir_len;
          if (ir_kind == snfcs_pkg::K_READ) begin
            operation_next = snfcs_pkg::OP_READ;
            phase_next     = snfcs_pkg::PH_CMD;
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_READ,
                                                   1'b0, snfcs_pkg::ST_OK);
            new_cnt = new_cnt + 2'd1;
          end else begin
            operation_next = snfcs_pkg::OP_PROG;
            phase_next     = snfcs_pkg::PH_WREN;
            page_left_next = snfcs_pkg::page_room(ir_addr & snfcs_pkg::ADDR_MASK, ir_len);
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_WREN,
                                                   1'b1, snfcs_pkg::ST_OK);
            new_cnt = new_cnt + 2'd1;
          end
        end
      end else if (phase == snfcs_pkg::PH_IDLE && ir_kind == snfcs_pkg::K_ERASE) begin
        if (erase_over) begin
          res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                 snfcs_pkg::ST_RANGE);
          new_cnt = new_cnt + 2'd1;
        end else begin
          operation_next = snfcs_pkg::OP_ERASE;
          cur_addr_next  = ir_addr & snfcs_pkg::ADDR_MASK;
          phase_next     = snfcs_pkg::PH_WREN;
          res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_WREN,
                                                 1'b1, snfcs_pkg::ST_OK);
          new_cnt = new_cnt + 2'd1;
        end
      end else if (phase == snfcs_pkg::PH_IDLE && ir_kind == snfcs_pkg::K_PROBE) begin
        operation_next = snfcs_pkg::OP_PROBE;
        abi_next       = 2'd0;
        phase_next     = snfcs_pkg::PH_PROBE;
        res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_RDID,
                                               1'b0, snfcs_pkg::ST_OK);
        new_cnt = new_cnt + 2'd1;
      end else if (ir_kind == snfcs_pkg::K_RESPONSE && phase != snfcs_pkg::PH_IDLE &&
                   phase != snfcs_pkg::PH_WAIT_DATA) begin
        case (phase)
          snfcs_pkg::PH_WREN: begin
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI,
              (operation == snfcs_pkg::OP_PROG) ? snfcs_pkg::OPC_PP : snfcs_pkg::OPC_SE4K,
              1'b0, snfcs_pkg::ST_OK);
            new_cnt    = new_cnt + 2'd1;
            phase_next = snfcs_pkg::PH_CMD;
          end
          snfcs_pkg::PH_CMD: begin
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, cur_addr[23:16], 1'b0,
                                                   snfcs_pkg::ST_OK);
            new_cnt    = new_cnt + 2'd1;
            abi_next   = 2'd0;
            phase_next = snfcs_pkg::PH_ADDR;
          end
          snfcs_pkg::PH_ADDR: begin
            if (abi == 2'd0) begin
              abi_next = 2'd1;
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, cur_addr[15:8], 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt = new_cnt + 2'd1;
            end else if (abi == 2'd1) begin
              abi_next = 2'd2;
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, cur_addr[7:0],
                operation == snfcs_pkg::OP_ERASE, snfcs_pkg::ST_OK);
              new_cnt = new_cnt + 2'd1;
            end else if (operation == snfcs_pkg::OP_READ) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                remaining == 25'd1, snfcs_pkg::ST_OK);
              new_cnt    = new_cnt + 2'd1;
              phase_next = snfcs_pkg::PH_READ;
            end else if (operation == snfcs_pkg::OP_PROG) begin
              phase_next = snfcs_pkg::PH_WAIT_DATA;
            end else begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_RDSR,
                                                     1'b0, snfcs_pkg::ST_OK);
              new_cnt    = new_cnt + 2'd1;
              phase_next = snfcs_pkg::PH_RDSR;
            end
          end
          snfcs_pkg::PH_READ: begin
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_HOST, ir_db, 1'b0,
                                                   snfcs_pkg::ST_OK);
            new_cnt        = new_cnt + 2'd1;
            remaining_next = rem_dec;
            if (rem_dec == '0) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt        = new_cnt + 2'd1;
              phase_next     = snfcs_pkg::PH_IDLE;
              operation_next = snfcs_pkg::OP_NONE;
            end else begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                rem_dec == 25'd1, snfcs_pkg::ST_OK);
              new_cnt = new_cnt + 2'd1;
            end
          end
          snfcs_pkg::PH_DATA: begin
            if (page_left != '0) begin
              phase_next = snfcs_pkg::PH_WAIT_DATA;
            end else begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_RDSR,
                                                     1'b0, snfcs_pkg::ST_OK);
              new_cnt    = new_cnt + 2'd1;
              phase_next = snfcs_pkg::PH_RDSR;
            end
          end
          snfcs_pkg::PH_RDSR: begin
            res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY, 1'b0,
                                                   snfcs_pkg::ST_OK);
            new_cnt         = new_cnt + 2'd1;
            poll_count_next = 16'd1;
            phase_next      = snfcs_pkg::PH_POLL;
          end
          snfcs_pkg::PH_POLL: begin
            // Busy clear or poll budget spent: release chip select after one dummy.
            if (!ir_db[0] || poll_count >= poll_limit) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                                                     1'b1, snfcs_pkg::ST_OK);
              new_cnt    = new_cnt + 2'd1;
              phase_next = snfcs_pkg::PH_RELEASE;
            end else begin
              poll_count_next = poll_count + 16'd1;
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                                                     1'b0, snfcs_pkg::ST_OK);
              new_cnt = new_cnt + 2'd1;
            end
          end
          snfcs_pkg::PH_RELEASE: begin
            if (operation == snfcs_pkg::OP_PROG && remaining != '0) begin
              // Open the next page.
              page_left_next = snfcs_pkg::page_room(cur_addr, remaining);
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::OPC_WREN,
                                                     1'b1, snfcs_pkg::ST_OK);
              new_cnt    = new_cnt + 2'd1;
              phase_next = snfcs_pkg::PH_WREN;
            end else begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt        = new_cnt + 2'd1;
              phase_next     = snfcs_pkg::PH_IDLE;
              operation_next = snfcs_pkg::OP_NONE;
            end
          end
          default: begin
            // Id probe: dummies trail 9F and id bytes 1-2; three id bytes to host.
            if (abi == 2'd0) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                                                     1'b0, snfcs_pkg::ST_OK);
              new_cnt  = new_cnt + 2'd1;
              abi_next = 2'd1;
            end else if (abi == 2'd1) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_HOST, ir_db, 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt = new_cnt + 2'd1;
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                                                     1'b0, snfcs_pkg::ST_OK);
              new_cnt  = new_cnt + 2'd1;
              abi_next = 2'd2;
            end else if (abi == 2'd2) begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_HOST, ir_db, 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt      = new_cnt + 2'd1;
              id_hold_next = {ir_db, 8'h00};
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, snfcs_pkg::DUMMY,
                                                     1'b1, snfcs_pkg::ST_OK);
              new_cnt  = new_cnt + 2'd1;
              abi_next = 2'd3;
            end else begin
              res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_HOST, ir_db, 1'b0,
                                                     snfcs_pkg::ST_OK);
              new_cnt        = new_cnt + 2'd1;
              id_hold_next   = jedec;
              phase_next     = snfcs_pkg::PH_IDLE;
              operation_next = snfcs_pkg::OP_NONE;
              if (jedec == 16'h0000 || jedec == 16'hFFFF) begin
                present_next  = 1'b0;
                size_exp_next = 4'd0;
                res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                       snfcs_pkg::ST_ABSENT);
              end else begin
                present_next  = 1'b1;
                size_exp_next = jedec[3:0];
                res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                                       snfcs_pkg::ST_OK);
              end
              new_cnt = new_cnt + 2'd1;
            end
          end
        endcase
      end else if (ir_kind == snfcs_pkg::K_DATA && phase == snfcs_pkg::PH_WAIT_DATA) begin
        page_left_next = pl_dec;
        remaining_next = rem_dec;
        cur_addr_next  = (cur_addr + 24'd1) & snfcs_pkg::ADDR_MASK;
        res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_SPI, ir_db, pl_dec == '0,
                                               snfcs_pkg::ST_OK);
        new_cnt    = new_cnt + 2'd1;
        phase_next = snfcs_pkg::PH_DATA;
      end else begin
        // Out of turn: refuse, leave the pending operation alone.
        res_new[new_cnt] = snfcs_pkg::make_res(snfcs_pkg::R_DONE, 8'h00, 1'b0,
                                               snfcs_pkg::ST_REFUSED);
        new_cnt = new_cnt + 2'd1;
      end
    end

    // Mark the final result of this item.
    if (new_cnt != 2'd0) begin
      res_new[new_cnt - 2'd1].last = 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= snfcs_pkg::POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (item_ready) begin
      ir_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      ir_kind <= kind;
      ir_addr <= address;
      ir_len  <= length;
      ir_db   <= data_byte;
    end
  end

  // Sequencer state advances when the decoded item moves into the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      operation  <= snfcs_pkg::OP_NONE;
      phase      <= snfcs_pkg::PH_IDLE;
      abi        <= 2'd0;
      cur_addr   <= '0;
      remaining  <= '0;
      page_left  <= '0;
      poll_count <= '0;
      size_exp   <= '0;
      present    <= 1'b0;
      id_hold    <= '0;
    end else if (load) begin
      operation  <= operation_next;
      phase      <= phase_next;
      abi        <= abi_next;
      cur_addr   <= cur_addr_next;
      remaining  <= remaining_next;
      page_left  <= page_left_next;
      poll_count <= poll_count_next;
      size_exp   <= size_exp_next;
      present    <= present_next;
      id_hold    <= id_hold_next;
    end
  end

  // Result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt  <= 2'd0;
      res_head <= 2'd0;
    end else if (load) begin
      res_cnt  <= new_cnt;
      res_head <= 2'd0;
    end else if (out_take) begin
      res_cnt  <= res_cnt - 2'd1;
      res_head <= res_head + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 3; i++) begin
        res_q[i] <= res_new[i];
      end
    end
  end

  assign result_valid   = (res_cnt != 2'd0);
  assign result_kind    = res_q[res_head].kind;
  assign byte_value     = res_q[res_head].value;
  assign release_select = res_q[res_head].release_cs;
  assign status         = res_q[res_head].status;
  assign last           = res_q[res_head].last;

endmodule

/* hw/rtl/snfcs_checker.sv */
// Port-level checker for the SPI NOR command sequencer, bound to the top level.
// Depends on snfcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module snfcs_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [1:0] result_kind,
  input logic [7:0] byte_value,
  input logic       release_select,
  input logic [1:0] status,
  input logic       last
);

  // A stalled result beat holds.
  `SNFCS_ASSERT(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(byte_value) && $stable(result_kind) && $stable(last), "result changed while stalled")

  // Reset drops every buffered result.
  `SNFCS_ASSERT_ALWAYS(a_reset_empty, $past(rst) |-> !result_valid, "result valid right after reset")

  // A finished beat always closes its item.
  `SNFCS_ASSERT(a_done_last, result_valid && result_kind == snfcs_pkg::R_DONE |-> last, "finished beat not marked last")

  // A host data byte is always followed by another result of the same item.
  `SNFCS_ASSERT(a_host_not_last, result_valid && result_kind == snfcs_pkg::R_HOST |-> !last, "host byte marked last")

  // Only SPI bytes release chip select; only finished beats carry a status.
  `SNFCS_ASSERT(a_field_use, result_valid |-> (result_kind == snfcs_pkg::R_SPI || !release_select) && (result_kind == snfcs_pkg::R_DONE || status == snfcs_pkg::ST_OK), "field used by wrong result kind")

endmodule

bind spi_nor_flash_command_sequencer snfcs_checker u_snfcs_checker (.*);
